// ===== design/hms_pkg.sv =====
// package: payload structs, mode codes and division helpers for the hms time unit
package hms_pkg;

    localparam int SecsPerHour = 3600;
    localparam int SecsPerMin  = 60;
    localparam int SecW        = 20;
    localparam int DivW        = 32;

    typedef enum logic [2:0] {
        MODE_ADD     = 3'd0,
        MODE_SUB     = 3'd1,
        MODE_RATIO   = 3'd2,
        MODE_DIV     = 3'd3,
        MODE_MUL     = 3'd4,
        MODE_CMP     = 3'd5,
        MODE_CONVERT = 3'd6,
        MODE_NOP     = 3'd7
    } t_mode;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  a_hour;
        logic [5:0]  a_minute;
        logic [5:0]  a_second;
        logic [7:0]  b_hour;
        logic [5:0]  b_minute;
        logic [5:0]  b_second;
        logic [31:0] scalar;
    } t_in;

    typedef struct packed {
        logic [7:0]  res_hour;
        logic [5:0]  res_minute;
        logic [5:0]  res_second;
        logic [19:0] ratio;
        logic [19:0] total_seconds;
        logic        less;
        logic        equal;
        logic        greater;
        logic        overflow;
        logic        divide_by_zero;
    } t_out;

    // item context carried along the divider pipe
    typedef struct packed {
        logic [2:0]  mode;
        logic [19:0] total;
        logic        less;
        logic        equal;
        logic        greater;
        logic        dbz;
        logic        zero_res;
        logic        use_hms;
    } t_ctx;

    // one restoring-division step: shift in a dividend bit, try to subtract
    typedef struct packed {
        logic [DivW-1:0] rem;
        logic [DivW-1:0] quo;
        logic [DivW-1:0] dvd;
        logic [DivW-1:0] dvs;
    } t_div;

    function automatic t_div div_step(input t_div d);
        logic [DivW:0] trial;
        t_div          o;
        o     = d;
        trial = {d.rem, d.dvd[DivW-1]} - {1'b0, d.dvs};
        o.dvd = {d.dvd[DivW-2:0], 1'b0};
        if (!trial[DivW]) begin
            o.rem = trial[DivW-1:0];
            o.quo = {d.quo[DivW-2:0], 1'b1};
        end else begin
            o.rem = {d.rem[DivW-2:0], d.dvd[DivW-1]};
            o.quo = {d.quo[DivW-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== design/hms_front.sv =====
// front stage: seconds conversion, compare and divider operand setup
module hms_front
    import hms_pkg::*;
(
    input  t_in              i_req,
    output t_ctx             o_ctx,
    output logic [DivW-1:0]  o_dvd,
    output logic [DivW-1:0]  o_dvs,
    output logic [SecW-1:0]  o_a,
    output logic [SecW-1:0]  o_b
);
    logic [SecW-1:0] a, b;

    // seconds counts of both operands
    always_comb begin
        a = SecW'((SecW'(i_req.a_hour) * SecW'(SecsPerMin) + SecW'(i_req.a_minute))
                  * SecW'(SecsPerMin)) + SecW'(i_req.a_second);
        b = SecW'((SecW'(i_req.b_hour) * SecW'(SecsPerMin) + SecW'(i_req.b_minute))
                  * SecW'(SecsPerMin)) + SecW'(i_req.b_second);
    end

    assign o_a = a;
    assign o_b = b;

    // context, compare flags and divisor selection by mode; the dividend is always a
    always_comb begin
        o_ctx          = '0;
        o_ctx.mode     = i_req.mode;
        o_ctx.total    = a;
        o_dvd          = DivW'(a);
        o_dvs          = '0;
        unique case (t_mode'(i_req.mode))
            MODE_RATIO: begin
                o_dvs          = DivW'(b);
                o_ctx.dbz      = (b == '0);
                o_ctx.zero_res = (b == '0) || (b > a);
            end
            MODE_DIV: begin
                o_dvs          = i_req.scalar;
                o_ctx.dbz      = (i_req.scalar == '0);
                o_ctx.zero_res = (i_req.scalar == '0) || (i_req.scalar > DivW'(a));
                o_ctx.use_hms  = 1'b1;
            end
            MODE_CMP: begin
                o_ctx.less    = (a < b);
                o_ctx.equal   = (a == b);
                o_ctx.greater = (a > b);
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_CONVERT: o_ctx.use_hms = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== design/hms_time_arithmetic_unit.sv =====
// top level: pipelined hour/minute/second time arithmetic unit
// pipeline: 36 register stages (1 input stage, 32 divider stages of one restoring
// step each, 3 split/output stages)
// throughput: one request per cycle; the whole pipe advances when the output
// register is empty or being taken
// reset: synchronous active-low i_rst_n clears all stage valid bits
module hms_time_arithmetic_unit
    import hms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);
    localparam int NSt = DivW;

    logic advance;
    assign advance = !o_valid || i_ready;
    assign o_ready = advance;

    t_ctx            f_ctx;
    logic [DivW-1:0] f_dvd, f_dvs;
    logic [SecW-1:0] f_a, f_b;

    hms_front u_front (
        .i_req(i_data), .o_ctx(f_ctx), .o_dvd(f_dvd), .o_dvs(f_dvs),
        .o_a(f_a), .o_b(f_b)
    );

    // input stage: register front results and the add/sub/mul/convert seconds count
    logic            r_v0;
    t_ctx            r_ctx0;
    t_div            r_div0;
    logic [31:0]     r_t0;
    logic [31:0]     n_t0;

    always_comb begin
        unique case (t_mode'(f_ctx.mode))
            MODE_ADD:     n_t0 = 32'(f_a) + 32'(f_b);
            MODE_SUB:     n_t0 = (f_a > f_b) ? 32'(f_a - f_b) : '0;
            MODE_MUL:     n_t0 = 32'(64'(f_a) * 64'(i_data.scalar));
            MODE_CONVERT: n_t0 = i_data.scalar;
            default:      n_t0 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (advance) begin
            r_v0 <= i_valid;
        end
        if (advance) begin
            r_ctx0 <= f_ctx;
            r_t0   <= n_t0;
            r_div0 <= '{rem: '0, quo: '0, dvd: f_dvd, dvs: f_dvs};
        end
    end

    // divider pipe, one quotient bit per stage
    logic [NSt:0]    r_v;
    t_ctx            r_ctx [NSt+1];
    t_div            r_div [NSt+1];
    logic [31:0]     r_t   [NSt+1];

    assign r_v[0]   = r_v0;
    assign r_ctx[0] = r_ctx0;
    assign r_div[0] = r_div0;
    assign r_t[0]   = r_t0;

    for (genvar g = 0; g < NSt; g++) begin : g_div
        logic r_vs;
        t_ctx r_cs;
        t_div r_ds;
        logic [31:0] r_ts;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs <= 1'b0;
            end else if (advance) begin
                r_vs <= r_v[g];
            end
            if (advance) begin
                r_cs <= r_ctx[g];
                r_ds <= div_step(r_div[g]);
                r_ts <= r_t[g];
            end
        end
        assign r_v[g+1]   = r_vs;
        assign r_ctx[g+1] = r_cs;
        assign r_div[g+1] = r_ds;
        assign r_t[g+1]   = r_ts;
    end

    // split the final seconds count into hours, minutes, seconds
    logic        split_in_v;
    t_ctx        split_in_ctx;
    logic [31:0] split_in_t;
    logic [19:0] split_in_ratio;

    always_comb begin
        split_in_v     = r_v[NSt];
        split_in_ctx   = r_ctx[NSt];
        split_in_t     = r_t[NSt];
        split_in_ratio = '0;
        if (t_mode'(split_in_ctx.mode) == MODE_DIV) begin
            split_in_t = split_in_ctx.zero_res ? '0 : r_div[NSt].quo;
        end
        if (t_mode'(split_in_ctx.mode) == MODE_RATIO && !split_in_ctx.zero_res) begin
            split_in_ratio = r_div[NSt].quo[19:0];
        end
    end

    hms_split u_split (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(advance),
        .i_valid(split_in_v), .i_ctx(split_in_ctx), .i_secs(split_in_t),
        .i_ratio(split_in_ratio), .o_valid(o_valid), .o_data(o_data)
    );
endmodule

// ===== design/hms_split.sv =====
// output stages: seconds count to hours/minutes/seconds by reciprocal multiply
module hms_split
    import hms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_advance,
    input  logic        i_valid,
    input  t_ctx        i_ctx,
    input  logic [31:0] i_secs,
    input  logic [19:0] i_ratio,
    output logic        o_valid,
    output t_out        o_data
);
    // stage a: hours estimate via reciprocal of 3600
    localparam logic [63:0] RecipHour = 64'((64'd1 << 43) / SecsPerHour + 1);
    localparam logic [31:0] RecipMin  = 32'((32'd1 << 18) / SecsPerMin + 1);

    logic        r_va, r_vb;
    t_ctx        r_ca, r_cb;
    logic [19:0] r_ra, r_rb;
    logic [31:0] r_sa;
    logic [20:0] r_ha;
    logic [20:0] r_hb;
    logic [11:0] r_remb;
    logic [31:0] hmul_hi;
    logic [20:0] h_est;
    logic [31:0] h_prod;
    logic [31:0] h_rem;
    logic [20:0] h_fix;
    logic [11:0] h_rfix;

    // hour estimate: floor(t*recip>>43) may be one low; hi part kept 32x32
    always_comb begin
        hmul_hi = 32'((64'(i_secs) * 64'(RecipHour[31:0])) >> 32);
        h_est   = 21'(hmul_hi >> 11);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_advance) begin
            r_va <= i_valid;
            r_vb <= r_va;
            o_valid <= r_vb;
        end
        if (i_advance) begin
            r_ca <= i_ctx;
            r_ra <= i_ratio;
            r_sa <= i_secs;
            r_ha <= h_est;
        end
    end

    // stage b: correct the hour and get the remainder below 3600
    always_comb begin
        h_prod = 32'(r_ha) * 32'(SecsPerHour);
        h_rem  = r_sa - h_prod;
        h_fix  = r_ha;
        h_rfix = h_rem[11:0];
        if (h_rem >= 32'(SecsPerHour)) begin
            h_fix  = r_ha + 21'd1;
            h_rfix = 12'(h_rem - 32'(SecsPerHour));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_cb   <= r_ca;
            r_rb   <= r_ra;
            r_hb   <= h_fix;
            r_remb <= h_rfix;
        end
    end

    // stage c: minutes and seconds, assemble result
    logic [31:0] m_prod;
    logic [5:0]  m_q;
    logic [5:0]  s_r;
    t_out        n_out;

    always_comb begin
        m_prod = 32'(r_remb) * RecipMin;
        m_q    = 6'(m_prod >> 18);
        s_r    = 6'(r_remb - 12'(m_q) * 12'(SecsPerMin));
        n_out               = '0;
        n_out.total_seconds = r_cb.total;
        n_out.ratio         = r_rb;
        n_out.less          = r_cb.less;
        n_out.equal         = r_cb.equal;
        n_out.greater       = r_cb.greater;
        n_out.divide_by_zero = r_cb.dbz;
        if (r_cb.use_hms) begin
            n_out.res_hour   = r_hb[7:0];
            n_out.res_minute = m_q;
            n_out.res_second = s_r;
            n_out.overflow   = (r_hb > 21'd255);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            o_data <= n_out;
        end
    end
endmodule

// ===== design/hms_checker.sv =====
// checker: port-level properties of the hms time unit, bound to the top level
module hms_checker
    import hms_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);
    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // ready follows the output register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output");

    // compare flags are exclusive
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_data.less, o_data.equal, o_data.greater}) <= 1)
        else $error("compare flags not exclusive");

    // no valid result after a reset edge
    assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind hms_time_arithmetic_unit hms_checker u_hms_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);

// ===== test/hms_time_arithmetic_unit_tb.sv =====
// testbench: hms time arithmetic unit checked against an in-bench predictor
module hms_time_arithmetic_unit_tb;
    import hms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 60;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    t_out expected_results[$];
    int   mismatch_count;
    int   request_count;
    int   result_count;
    int   idle_cycles;
    bit   sink_hold;

    hms_time_arithmetic_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // split a seconds count into result time fields
    function automatic void split_seconds(input logic [31:0] secs, inout t_out r);
        logic [31:0] hours;
        logic [31:0] rest;
        hours = secs / 32'd3600;
        rest = secs % 32'd3600;
        r.res_hour = hours[7:0];
        r.res_minute = 6'(rest / 32'd60);
        r.res_second = 6'(rest % 32'd60);
        r.overflow = (hours > 32'd255);
    endfunction

    // expected result of one time operation
    function automatic t_out predict_time_op(input t_in req);
        t_out        r;
        logic [31:0] a_secs;
        logic [31:0] b_secs;
        logic [63:0] product;
        r = '0;
        a_secs = (32'(req.a_hour) * 60 + 32'(req.a_minute)) * 60 + 32'(req.a_second);
        b_secs = (32'(req.b_hour) * 60 + 32'(req.b_minute)) * 60 + 32'(req.b_second);
        r.total_seconds = a_secs[19:0];
        case (t_mode'(req.mode))
            MODE_ADD: begin
                split_seconds(a_secs + b_secs, r);
            end
            MODE_SUB: begin
                if (a_secs > b_secs) split_seconds(a_secs - b_secs, r);
            end
            MODE_RATIO: begin
                if (b_secs == 0) r.divide_by_zero = 1'b1;
                else if (b_secs <= a_secs) r.ratio = 20'(a_secs / b_secs);
            end
            MODE_DIV: begin
                if (req.scalar == 0) r.divide_by_zero = 1'b1;
                else if (req.scalar <= a_secs) split_seconds(a_secs / req.scalar, r);
            end
            MODE_MUL: begin
                product = 64'(a_secs) * 64'(req.scalar);
                split_seconds(product[31:0], r);
            end
            MODE_CMP: begin
                r.less = (a_secs < b_secs);
                r.equal = (a_secs == b_secs);
                r.greater = (a_secs > b_secs);
            end
            MODE_CONVERT: begin
                split_seconds(req.scalar, r);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // send one request with a random lead-in gap; valid drops only for a gap
    task automatic send_request(input t_in req);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_data <= req;
        i_valid <= 1'b1;
        expected_results.push_back(predict_time_op(req));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        request_count++;
    endtask

    function automatic t_in make_request(input t_mode m, input logic [7:0] ah,
                                         input logic [5:0] am, input logic [5:0] as_,
                                         input logic [7:0] bh, input logic [5:0] bm,
                                         input logic [5:0] bs, input logic [31:0] k);
        t_in req;
        req.mode = m;
        req.a_hour = ah; req.a_minute = am; req.a_second = as_;
        req.b_hour = bh; req.b_minute = bm; req.b_second = bs;
        req.scalar = k;
        return req;
    endfunction

    function automatic t_in random_request();
        t_in req;
        req = make_request(t_mode'($urandom_range(0, 7)),
                           8'($urandom), 6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
                           8'($urandom), 6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)),
                           $urandom);
        // out-of-range minutes and seconds now and then
        if ($urandom_range(0, 15) == 0) req.a_minute = 6'($urandom);
        if ($urandom_range(0, 15) == 0) req.b_second = 6'($urandom);
        // small operands and scalars so divide and multiply stay interesting
        case ($urandom_range(0, 3))
            0: req.scalar = $urandom_range(0, 100);
            1: req.scalar = $urandom_range(0, 1000000);
            default: begin
            end
        endcase
        if ($urandom_range(0, 3) == 0) begin
            req.b_hour = 8'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 7) == 0) begin
            req.b_hour = req.a_hour; req.b_minute = req.a_minute;
            req.b_second = req.a_second;
        end
        return req;
    endfunction

    // extremes and each special case
    task automatic test_directed();
        send_request(make_request(MODE_ADD, 8'd0, 6'd0, 6'd0, 8'd0, 6'd0, 6'd0, 32'd0));
        send_request(make_request(MODE_ADD, 8'd255, 6'd59, 6'd59, 8'd255, 6'd59, 6'd59, 0));
        send_request(make_request(MODE_ADD, 8'd255, 6'd63, 6'd63, 8'd255, 6'd63, 6'd63, 0));
        send_request(make_request(MODE_SUB, 8'd10, 6'd0, 6'd0, 8'd2, 6'd30, 6'd1, 0));
        send_request(make_request(MODE_SUB, 8'd1, 6'd0, 6'd0, 8'd2, 6'd0, 6'd0, 0));
        send_request(make_request(MODE_SUB, 8'd5, 6'd5, 6'd5, 8'd5, 6'd5, 6'd5, 0));
        send_request(make_request(MODE_RATIO, 8'd255, 6'd59, 6'd59, 8'd0, 6'd0, 6'd1, 0));
        send_request(make_request(MODE_RATIO, 8'd1, 6'd0, 6'd0, 8'd2, 6'd0, 6'd0, 0));
        send_request(make_request(MODE_RATIO, 8'd1, 6'd0, 6'd0, 8'd0, 6'd0, 6'd0, 0));
        send_request(make_request(MODE_DIV, 8'd3, 6'd0, 6'd0, 8'd0, 6'd0, 6'd0, 32'd0));
        send_request(make_request(MODE_DIV, 8'd3, 6'd0, 6'd0, 8'd0, 6'd0, 6'd0, 32'd7));
        send_request(make_request(MODE_DIV, 8'd0, 6'd0, 6'd5, 8'd0, 6'd0, 6'd0, 32'd6));
        send_request(make_request(MODE_DIV, 8'd255, 6'd59, 6'd59, 8'd0, 6'd0, 6'd0, 32'd1));
        send_request(make_request(MODE_MUL, 8'd255, 6'd59, 6'd59, 8'd0, 6'd0, 6'd0, '1));
        send_request(make_request(MODE_MUL, 8'd1, 6'd0, 6'd0, 8'd0, 6'd0, 6'd0, 32'd300));
        send_request(make_request(MODE_CMP, 8'd1, 6'd2, 6'd3, 8'd1, 6'd2, 6'd4, 0));
        send_request(make_request(MODE_CMP, 8'd1, 6'd2, 6'd3, 8'd1, 6'd2, 6'd3, 0));
        send_request(make_request(MODE_CMP, 8'd2, 6'd0, 6'd0, 8'd1, 6'd59, 6'd59, 0));
        send_request(make_request(MODE_CONVERT, 8'd0, 6'd0, 6'd0, 8'd0, 6'd0, 6'd0, '1));
        send_request(make_request(MODE_CONVERT, 8'd0, 6'd0, 6'd0, 8'd0, 6'd0, 6'd0, 32'd921599));
        send_request(make_request(MODE_NOP, 8'd255, 6'd63, 6'd63, 8'd255, 6'd63, 6'd63, '1));
    endtask

    // random requests of every mode
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_request(random_request());
    endtask

    // back-to-back requests with the sink always ready
    task automatic test_full_rate(input int count);
        t_in req;
        sink_hold = 1'b1;
        for (int i = 0; i < count; i++) begin
            req = random_request();
            i_data <= req;
            i_valid <= 1'b1;
            expected_results.push_back(predict_time_op(req));
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            request_count++;
        end
        i_valid <= 1'b0;
        sink_hold = 1'b0;
    endtask

    // result ready: random stalls, or always ready during the full-rate test
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = sink_hold ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_data);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_data !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, o_data);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog expired with %0d results pending", expected_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // sequence of tests
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        mismatch_count = 0;
        request_count = 0;
        result_count = 0;
        idle_cycles = 0;
        sink_hold = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(380);
        test_full_rate(60);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        $display("sent %0d requests over all eight modes, checked %0d results",
                 request_count, result_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/hms_pkg.sv
design/hms_front.sv
design/hms_time_arithmetic_unit.sv
design/hms_split.sv
design/hms_checker.sv
test/hms_time_arithmetic_unit_tb.sv
